>>> rtl/mle_pkg.sv
package mle_pkg;

   localparam int MAX_MONITORS_DEF = 8;
   localparam int MAP_LIMIT        = 8;
   localparam int EPOCH_W          = 32;
   localparam int ID_W             = 3;
   localparam int MASK_W           = 8;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int REQ_TDATA_W      = 40;
   localparam int RSP_TDATA_W      = 56;

   localparam logic [2:0] FN_START   = 3'd0;
   localparam logic [2:0] FN_PROPOSE = 3'd1;
   localparam logic [2:0] FN_ACK     = 3'd2;
   localparam logic [2:0] FN_VICTORY = 3'd3;
   localparam logic [2:0] FN_TIMER   = 3'd4;

   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_PROPOSE = 2'd1;
   localparam logic [1:0] SEND_ACK     = 2'd2;
   localparam logic [1:0] SEND_VICTORY = 2'd3;

   localparam logic [1:0] TMR_NONE        = 2'd0;
   localparam logic [1:0] TMR_LEASE       = 2'd1;
   localparam logic [1:0] TMR_LEASE_EXTRA = 2'd2;
   localparam logic [1:0] TMR_CANCEL      = 2'd3;

   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_WON  = 2'd1;
   localparam logic [1:0] OUT_LOST = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_NUM_MONITORS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MY_ID        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_EPOCH  = 2'd2;

   localparam logic [EPOCH_W-1:0] EPOCH_RESET = 32'd1;

   typedef struct packed {
      logic               lt;
      logic               gt;
      logic               next_eq;
      logic               wrap;
      logic [EPOCH_W-1:0] inc;
   } mle_cmp_type;

endpackage

>>> rtl/mle_epoch_unit.sv
module mle_epoch_unit (
   input  logic [31:0]          epoch_i,
   input  logic [31:0]          operand_i,
   output mle_pkg::mle_cmp_type cmp_o
);
   import mle_pkg::*;

   logic [EPOCH_W:0] sum;

   assign sum           = {1'b0, epoch_i} + {{EPOCH_W{1'b0}}, 1'b1};
   assign cmp_o.inc     = sum[EPOCH_W-1:0];
   assign cmp_o.wrap    = sum[EPOCH_W];
   assign cmp_o.lt      = operand_i < epoch_i;
   assign cmp_o.gt      = operand_i > epoch_i;
   assign cmp_o.next_eq = operand_i == sum[EPOCH_W-1:0];

endmodule

>>> rtl/monitor_leader_election.sv
// After acceptance an event passes S_EVAL and, by function, S_P_BEGIN, S_BEGIN, S_P_DECIDE,
// S_ACK_CHECK or S_VICTORY; on a path that can send, the message words and a step to close the
// message run follow; then the status word. One event at a time, the next taken after that word;
// a propose that opens an election and defers, with seven propose words and an ack, is longest.
// Reset (synchronous, active high): epoch 1, election state and registers to defaults.
module monitor_leader_election #(
   parameter int MAX_MONITORS = mle_pkg::MAX_MONITORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sender_id[2:0], msg_epoch[34:3], sender_in_quorum[35], zero pad
   input  logic [mle_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func[2:0]
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // dest_id[2:0], epoch_out[34:3], timer_action[36:35], outcome[38:37],
   // quorum_mask[46:39], leader_id[49:47], error[50], zero pad
   output logic [mle_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // send_op[1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mle_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mle_pkg::*;

   localparam logic [3:0] MapCap = 4'((MAX_MONITORS < MAP_LIMIT) ? MAX_MONITORS : MAP_LIMIT);

   typedef enum logic [3:0] {
      S_IDLE, S_EVAL, S_P_BEGIN, S_BEGIN, S_P_DECIDE,
      S_ACK_CHECK, S_VICTORY, S_EMIT, S_STATUS
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         num_mon_ff, num_mon_in;
   logic [ID_W-1:0]    my_id_ff, my_id_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               electing_ff, electing_in;
   logic [MASK_W-1:0]  acked_ff, acked_in;
   logic               defv_ff, defv_in;
   logic [ID_W-1:0]    defl_ff, defl_in;

   logic [2:0]         func_ff, func_in;
   logic [ID_W-1:0]    from_ff, from_in;
   logic [EPOCH_W-1:0] me_ff, me_in;
   logic               inq_ff, inq_in;
   logic [1:0]         tmr_ff, tmr_in;
   logic               err_ff, err_in;
   logic [1:0]         outcome_ff, outcome_in;
   logic [MASK_W-1:0]  qmask_ff, qmask_in;
   logic [ID_W-1:0]    leader_ff, leader_in;
   logic [1:0]         bop_ff, bop_in;
   logic [MASK_W-1:0]  bmask_ff, bmask_in;
   logic               ack_ff, ack_in;

   mle_cmp_type        cmp;
   logic [3:0]         map_n;
   logic [MASK_W-1:0]  pmask;
   logic [MASK_W-1:0]  me_bit;
   logic [MASK_W-1:0]  low_bit;
   logic [3:0]         acked_pop;
   logic               req_fire, rsp_fire, csr_fire;
   logic               msg_word;

   function automatic logic [3:0] pop8(input logic [MASK_W-1:0] v);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < MASK_W; i++) c = c + {3'd0, v[i]};
      return c;
   endfunction

   function automatic logic [ID_W-1:0] low_index(input logic [MASK_W-1:0] v);
      logic [ID_W-1:0] idx;
      idx = '0;
      for (int i = MASK_W - 1; i >= 0; i--) if (v[i]) idx = ID_W'(i);
      return idx;
   endfunction

   mle_epoch_unit u_epoch (
      .epoch_i   (epoch_ff),
      .operand_i (me_ff),
      .cmp_o     (cmp)
   );

   assign map_n     = (num_mon_ff > MapCap) ? MapCap : num_mon_ff;
   assign me_bit    = MASK_W'(1) << my_id_ff;
   assign low_bit   = bmask_ff & (~bmask_ff + MASK_W'(1));
   assign acked_pop = pop8(acked_ff);

   always_comb begin
      for (int i = 0; i < MASK_W; i++)
         pmask[i] = (4'(i) < map_n) && (ID_W'(i) != my_id_ff);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign msg_word   = (state_ff == S_EMIT) && ((bmask_ff != '0) || ack_ff);
   assign rsp_tvalid = msg_word || (state_ff == S_STATUS);
   assign rsp_tlast  = (state_ff == S_STATUS);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;

   always_comb begin
      rsp_tuser = SEND_NONE;
      rsp_tdata = '0;
      if (msg_word) begin
         rsp_tuser       = (bmask_ff != '0) ? bop_ff : SEND_ACK;
         rsp_tdata[2:0]  = (bmask_ff != '0) ? low_index(bmask_ff) : from_ff;
         rsp_tdata[34:3] = epoch_ff;
      end else if (state_ff == S_STATUS) begin
         rsp_tdata[34:3]  = epoch_ff;
         rsp_tdata[36:35] = tmr_ff;
         rsp_tdata[38:37] = outcome_ff;
         rsp_tdata[46:39] = qmask_ff;
         rsp_tdata[49:47] = leader_ff;
         rsp_tdata[50]    = err_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      num_mon_in  = num_mon_ff;
      my_id_in    = my_id_ff;
      epoch_in    = epoch_ff;
      electing_in = electing_ff;
      acked_in    = acked_ff;
      defv_in     = defv_ff;
      defl_in     = defl_ff;
      func_in     = func_ff;
      from_in     = from_ff;
      me_in       = me_ff;
      inq_in      = inq_ff;
      tmr_in      = tmr_ff;
      err_in      = err_ff;
      outcome_in  = outcome_ff;
      qmask_in    = qmask_ff;
      leader_in   = leader_ff;
      bop_in      = bop_ff;
      bmask_in    = bmask_ff;
      ack_in      = ack_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in    = req_tuser;
               from_in    = req_tdata[2:0];
               me_in      = req_tdata[34:3];
               inq_in     = req_tdata[35];
               tmr_in     = TMR_NONE;
               err_in     = 1'b0;
               outcome_in = OUT_NONE;
               qmask_in   = '0;
               leader_in  = '0;
               bmask_in   = '0;
               ack_in     = 1'b0;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            case (func_ff)
               FN_START: state_in = S_BEGIN;
               FN_TIMER: begin
                  if (electing_ff && (acked_pop > (map_n >> 1))) begin
                     outcome_in = OUT_WON;
                     state_in   = S_VICTORY;
                  end else begin
                     state_in = S_BEGIN;
                  end
               end
               FN_PROPOSE: begin
                  if (!me_ff[0]) err_in = 1'b1;
                  if (cmp.gt) begin
                     epoch_in    = me_ff;
                     electing_in = 1'b0;
                     acked_in    = '0;
                     defv_in     = 1'b0;
                  end
                  if (!cmp.gt && cmp.lt && !epoch_ff[0] && !inq_ff) state_in = S_P_BEGIN;
                  else state_in = S_P_DECIDE;
               end
               FN_ACK: begin
                  state_in = S_STATUS;
                  if (!cmp.lt) begin
                     if (!me_ff[0]) err_in = 1'b1;
                     if (cmp.gt) begin
                        epoch_in    = me_ff;
                        electing_in = 1'b0;
                        acked_in    = '0;
                        defv_in     = 1'b0;
                        state_in    = S_BEGIN;
                     end else if (electing_ff) begin
                        acked_in = acked_ff | (MASK_W'(1) << from_ff);
                        state_in = S_ACK_CHECK;
                     end else if (!defv_ff) begin
                        err_in = 1'b1;
                     end
                  end
               end
               FN_VICTORY: begin
                  state_in = S_STATUS;
                  if (!cmp.lt) begin
                     if (!(from_ff < my_id_ff) || me_ff[0] || !cmp.next_eq || !cmp.gt)
                        err_in = 1'b1;
                     epoch_in    = me_ff;
                     electing_in = 1'b0;
                     acked_in    = '0;
                     defv_in     = 1'b0;
                     outcome_in  = OUT_LOST;
                     leader_in   = from_ff;
                     tmr_in      = TMR_CANCEL;
                  end
               end
               default: begin
                  err_in   = 1'b1;
                  state_in = S_STATUS;
               end
            endcase
         end
         S_P_BEGIN, S_BEGIN: begin
            if (!epoch_ff[0]) begin
               if (cmp.wrap) err_in = 1'b1;
               epoch_in = cmp.inc;
               defv_in  = 1'b0;
               acked_in = me_bit;
            end else begin
               acked_in = acked_ff | me_bit;
            end
            electing_in = 1'b1;
            bmask_in    = pmask;
            bop_in      = SEND_PROPOSE;
            tmr_in      = TMR_LEASE;
            state_in    = (state_ff == S_P_BEGIN) ? S_P_DECIDE : S_EMIT;
         end
         S_P_DECIDE: begin
            state_in = S_EMIT;
            if (my_id_ff < from_ff) begin
               if (defv_ff) begin
                  if (!(defl_ff < from_ff)) err_in = 1'b1;
               end else if (!electing_ff) begin
                  state_in = S_BEGIN;
               end
            end else if (!defv_ff || (defl_ff >= from_ff)) begin
               if (electing_ff) begin
                  acked_in    = '0;
                  electing_in = 1'b0;
               end
               defv_in = 1'b1;
               defl_in = from_ff;
               ack_in  = 1'b1;
               tmr_in  = TMR_LEASE_EXTRA;
            end
         end
         S_ACK_CHECK: begin
            if (acked_pop == map_n) begin
               outcome_in = OUT_WON;
               state_in   = S_VICTORY;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_VICTORY: begin
            qmask_in    = acked_ff;
            bmask_in    = acked_ff & ~me_bit;
            bop_in      = SEND_VICTORY;
            tmr_in      = TMR_CANCEL;
            if (!epoch_ff[0] || cmp.wrap) err_in = 1'b1;
            epoch_in    = cmp.inc;
            electing_in = 1'b0;
            acked_in    = '0;
            defv_in     = 1'b0;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (bmask_ff != '0) begin
               if (rsp_fire) bmask_in = bmask_ff & ~low_bit;
            end else if (ack_ff) begin
               if (rsp_fire) ack_in = 1'b0;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_fire) begin
         case (csr_index)
            REG_NUM_MONITORS: num_mon_in = csr_data[3:0];
            REG_MY_ID:        my_id_in   = csr_data[ID_W-1:0];
            REG_START_EPOCH:  epoch_in   = (csr_data == '0) ? EPOCH_RESET : csr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         num_mon_ff  <= 4'd1;
         my_id_ff    <= '0;
         epoch_ff    <= EPOCH_RESET;
         electing_ff <= 1'b0;
         acked_ff    <= '0;
         defv_ff     <= 1'b0;
         defl_ff     <= '0;
         bmask_ff    <= '0;
         ack_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         num_mon_ff  <= num_mon_in;
         my_id_ff    <= my_id_in;
         epoch_ff    <= epoch_in;
         electing_ff <= electing_in;
         acked_ff    <= acked_in;
         defv_ff     <= defv_in;
         defl_ff     <= defl_in;
         bmask_ff    <= bmask_in;
         ack_ff      <= ack_in;
      end
      func_ff    <= func_in;
      from_ff    <= from_in;
      me_ff      <= me_in;
      inq_ff     <= inq_in;
      tmr_ff     <= tmr_in;
      err_ff     <= err_in;
      outcome_ff <= outcome_in;
      qmask_ff   <= qmask_in;
      leader_ff  <= leader_in;
      bop_ff     <= bop_in;
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result word is pending");

   a_ready_after_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not ready after status word");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == SEND_NONE)))
      else $error("status word and message word mixed up");
`endif

endmodule
